// ===== rtl/core/gtr_pkg.sv =====
`timescale 1ns / 1ps

package gtr_pkg;

	localparam int SCREEN_WIDTH  = 320;
	localparam int SCREEN_HEIGHT = 200;

	localparam logic [15:0] SCREEN_W16 = 16'(SCREEN_WIDTH);
	localparam logic [15:0] SCREEN_H16 = 16'(SCREEN_HEIGHT);

	localparam logic [7:0] INK_SKIP = 8'hFF;

	localparam int PIX_PER_BYTE = 4;

	// job queue between front and back; depth is a power of two
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int CFG_ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_PEN_X       = 3'd0,
		REG_PEN_Y       = 3'd1,
		REG_ROW_PIXELS  = 3'd2,
		REG_CELL_HEIGHT = 3'd3,
		REG_INK_LEVEL0  = 3'd4,
		REG_INK_LEVEL1  = 3'd5,
		REG_INK_LEVEL2  = 3'd6,
		REG_INK_LEVEL3  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [15:0]                     pen_x;
		logic [15:0]                     pen_y;
		logic [7:0]                      row_pixels;
		logic [7:0]                      cell_height;
		logic [PIX_PER_BYTE-1:0][7:0]    ink;
	} cfg_t;

	// one classified byte: base address of its leftmost pixel, which pixels
	// get written, and the colour of each
	typedef struct packed {
		logic [15:0]                     addr0;
		logic [PIX_PER_BYTE-1:0]         mask;
		logic [PIX_PER_BYTE-1:0][7:0]    colour;
	} job_t;

endpackage

// ===== rtl/core/glyph_2bpp_rasterizer.sv =====
`timescale 1ns / 1ps

// Glyph rasterizer for 2-bit-per-pixel bitmaps. Feed the glyph one bitmap
// byte per beat in row order (ceil(width/4) bytes per row, leftmost pixel in
// bits 7..6) and set tuser on the first byte of a glyph to restart the row and
// byte counters. Each byte yields zero to four framebuffer writes, left to
// right, as address (row * 320 + column, wrapped to 16 bits) and colour, with
// tlast on the final write of that byte. A byte that writes nothing gives no
// beat at all. Ink 0xFF leaves a pixel alone; padding columns, rows at or past
// cell_height and pixels off the 320x200 screen are dropped; width zero draws
// nothing and leaves the counters alone (a start flag still clears them). The
// front end takes one byte per cycle unless the job queue is full, registers
// it in stage 1 and makes a job of it there; a four-entry job queue decouples
// it from the back end, which issues at most one write per cycle and stalls
// while the output is not ready. A byte gives 1 to 4 writes (none when empty),
// and that single write port sets the sustained rate; a write passes stage 1,
// the job queue, the back end's job register and its output register. Program
// the registers over APB (byte address 4*index) only while the block is idle.

module glyph_2bpp_rasterizer (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// bitmap in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] bitmap_byte
	input  logic [0:0]  s_axis_tuser,   // [0] glyph_start
	// framebuffer writes out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [15:0] pixel_address, [23:16] pixel_colour
	output logic        m_axis_tlast    // last_write
);
	import gtr_pkg::*;

	cfg_t        cfg;
	job_t        push_job;
	job_t        head_job;
	logic        push;
	logic        q_full;
	logic        pop;
	logic        q_valid;
	logic [15:0] pix_addr;
	logic [7:0]  pix_colour;

	gtr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// front: counters, bounds and ink lookup per byte
	gtr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_start (s_axis_tuser[0]),
		.push     (push),
		.job      (push_job),
		.q_full   (q_full)
	);

	gtr_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (push_job),
		.full      (q_full),
		.pop       (pop),
		.dout      (head_job),
		.not_empty (q_valid)
	);

	// back: at most one write beat per cycle, held while the output is not ready
	gtr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_job      (head_job),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_addr   (pix_addr),
		.out_colour (pix_colour),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {pix_colour, pix_addr};

endmodule

// ===== rtl/core/gtr_regs.sv =====
`timescale 1ns / 1ps

module gtr_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [gtr_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output gtr_pkg::cfg_t                  cfg
);
	import gtr_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pen_x       <= '0;
			cfg_q.pen_y       <= '0;
			cfg_q.row_pixels  <= '0;
			cfg_q.cell_height <= '0;
			cfg_q.ink         <= {PIX_PER_BYTE{INK_SKIP}};
		end else if (wr_en) begin
			case (idx)
				REG_PEN_X:       cfg_q.pen_x       <= pwdata[15:0];
				REG_PEN_Y:       cfg_q.pen_y       <= pwdata[15:0];
				REG_ROW_PIXELS:  cfg_q.row_pixels  <= pwdata[7:0];
				REG_CELL_HEIGHT: cfg_q.cell_height <= pwdata[7:0];
				REG_INK_LEVEL0:  cfg_q.ink[0]      <= pwdata[7:0];
				REG_INK_LEVEL1:  cfg_q.ink[1]      <= pwdata[7:0];
				REG_INK_LEVEL2:  cfg_q.ink[2]      <= pwdata[7:0];
				REG_INK_LEVEL3:  cfg_q.ink[3]      <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PEN_X:       prdata = {16'd0, cfg_q.pen_x};
			REG_PEN_Y:       prdata = {16'd0, cfg_q.pen_y};
			REG_ROW_PIXELS:  prdata = {24'd0, cfg_q.row_pixels};
			REG_CELL_HEIGHT: prdata = {24'd0, cfg_q.cell_height};
			REG_INK_LEVEL0:  prdata = {24'd0, cfg_q.ink[0]};
			REG_INK_LEVEL1:  prdata = {24'd0, cfg_q.ink[1]};
			REG_INK_LEVEL2:  prdata = {24'd0, cfg_q.ink[2]};
			REG_INK_LEVEL3:  prdata = {24'd0, cfg_q.ink[3]};
			default:         prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/gtr_front.sv =====
`timescale 1ns / 1ps

module gtr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  gtr_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_byte,
	input  logic          in_start,
	output logic          push,
	output gtr_pkg::job_t job,
	input  logic          q_full
);
	import gtr_pkg::*;

	// walk state
	logic [5:0]  bir_q;
	logic [7:0]  row_q;

	// stage 1: accepted byte with its position resolved
	logic        valid_s1;
	logic [7:0]  bits_s1;
	logic [5:0]  bir_s1;
	logic [7:0]  row_s1;
	logic [16:0] dy_s1;
	logic [16:0] dx0_s1;

	logic        accept;
	logic [5:0]  bir_eff;
	logic [7:0]  row_eff;
	logic [6:0]  stride;
	logic [8:0]  w_plus3;
	logic        row_wrap;
	logic [5:0]  bir_nxt;
	logic [7:0]  row_nxt;

	logic                     row_ok;
	logic [PIX_PER_BYTE-1:0]  mask;
	logic [PIX_PER_BYTE-1:0][7:0] colour;
	logic [8:0]               col;
	logic [16:0]              dxk;
	logic [1:0]               lvl;
	logic [15:0]              row_base;

	assign accept = in_valid && in_ready;

	always_comb begin
		bir_eff  = in_start ? 6'd0 : bir_q;
		row_eff  = in_start ? 8'd0 : row_q;
		// bytes per row = ceil(width / 4)
		w_plus3  = {1'b0, cfg.row_pixels} + 9'd3;
		stride   = w_plus3[8:2];
		row_wrap = ({1'b0, bir_eff} + 7'd1) >= stride;
		if (cfg.row_pixels == 8'd0) begin
			bir_nxt = bir_eff;
			row_nxt = row_eff;
		end else if (row_wrap) begin
			bir_nxt = 6'd0;
			row_nxt = (row_eff == 8'hFF) ? row_eff : row_eff + 8'd1;
		end else begin
			bir_nxt = bir_eff + 6'd1;
			row_nxt = row_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bir_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			bir_q <= bir_nxt;
			row_q <= row_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= accept && (cfg.row_pixels != 8'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bits_s1 <= in_byte;
			bir_s1  <= bir_eff;
			row_s1  <= row_eff;
			dy_s1   <= {cfg.pen_y[15], cfg.pen_y} + {9'd0, row_eff};
			dx0_s1  <= {cfg.pen_x[15], cfg.pen_x} + {9'd0, bir_eff, 2'b00};
		end
	end

	// classify the four pixels of the stage-1 byte
	always_comb begin
		row_ok = (row_s1 < cfg.cell_height) && !dy_s1[16] && (dy_s1[15:0] < SCREEN_H16);
		mask   = '0;
		colour = '0;
		col    = '0;
		dxk    = '0;
		lvl    = '0;
		for (int k = 0; k < PIX_PER_BYTE; k++) begin
			col       = {1'b0, bir_s1, 2'b00} + 9'(k);
			dxk       = dx0_s1 + 17'(k);
			lvl       = bits_s1[7-2*k -: 2];
			colour[k] = cfg.ink[lvl];
			mask[k]   = row_ok && (col < {1'b0, cfg.row_pixels}) && !dxk[16] &&
			            (dxk[15:0] < SCREEN_W16) && (cfg.ink[lvl] != INK_SKIP);
		end
	end

	// address wraps to 16 bits
	assign row_base   = dy_s1[15:0] * SCREEN_W16;
	assign job.addr0  = row_base + dx0_s1[15:0];
	assign job.mask   = mask;
	assign job.colour = colour;

	assign push     = valid_s1 && (|mask) && !q_full;
	assign in_ready = !valid_s1 || !(|mask) || !q_full;

	a_push_has_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> job.mask != '0)
		else $error("queued job with no pixels");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !in_ready) |=> (valid_s1 && $stable(bits_s1) && $stable(dy_s1)))
		else $error("stage 1 lost a stalled byte");

	a_start_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_start) |=> (bir_q <= 6'd1) && (row_q <= 8'd1))
		else $error("start flag did not restart walk");

endmodule

// ===== rtl/core/gtr_fifo.sv =====
`timescale 1ns / 1ps

module gtr_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gtr_pkg::job_t din,
	output logic          full,
	input  logic          pop,
	output gtr_pkg::job_t dout,
	output logic          not_empty
);
	import gtr_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full      = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign dout      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/gtr_back.sv =====
`timescale 1ns / 1ps

module gtr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  gtr_pkg::job_t q_job,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [15:0]   out_addr,
	output logic [7:0]    out_colour,
	output logic          out_last
);
	import gtr_pkg::*;

	// job being drained
	logic [PIX_PER_BYTE-1:0]      mask_q;
	logic [15:0]                  addr0_q;
	logic [PIX_PER_BYTE-1:0][7:0] colour_q;

	// output register
	logic                         out_valid_q;
	logic [15:0]                  out_addr_q;
	logic [7:0]                   out_colour_q;
	logic                         out_last_q;

	logic                         out_free;
	logic                         emit;
	logic [1:0]                   pick;
	logic [PIX_PER_BYTE-1:0]      mask_after;

	assign out_free = !out_valid_q || out_ready;
	assign emit     = (|mask_q) && out_free;

	// leftmost pending pixel first
	always_comb begin
		if (mask_q[0]) begin
			pick = 2'd0;
		end else if (mask_q[1]) begin
			pick = 2'd1;
		end else if (mask_q[2]) begin
			pick = 2'd2;
		end else begin
			pick = 2'd3;
		end
		mask_after       = mask_q;
		mask_after[pick] = 1'b0;
	end

	assign pop = q_valid && ((mask_q == '0) || (emit && (mask_after == '0)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (pop) begin
			mask_q <= q_job.mask;
		end else if (emit) begin
			mask_q <= mask_after;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			addr0_q  <= q_job.addr0;
			colour_q <= q_job.colour;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_addr_q   <= addr0_q + {14'd0, pick};
			out_colour_q <= colour_q[pick];
			out_last_q   <= (mask_after == '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_addr   = out_addr_q;
	assign out_colour = out_colour_q;
	assign out_last   = out_last_q;

	a_no_skip_ink: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_colour_q != INK_SKIP)
		else $error("skip ink reached the output");

	a_pending_drains: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("pending pixel not presented");

	a_last_ends_job: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && (mask_after != '0)) |=> (mask_q != '0) && !out_last_q)
		else $error("beat marked last while pixels remain");

endmodule
